FILE: hw/rtl/ksrp_pkg.sv
package ksrp_pkg;

  // command codes
  localparam logic [1:0] CMD_SCAN  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_ACK   = 2'd3;

  // register selects
  localparam logic [2:0] REG_STATE  = 3'd0;
  localparam logic [2:0] REG_CODE   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd3;

  localparam int          NUM_ROWS     = 11;
  localparam int          MASK_BIT_POS = 6;
  localparam int          SHIFT_BIT    = 2;
  localparam int          VEC_SEL_BIT  = 1;
  localparam logic [15:0] STATUS_BASE  = 16'h8080;
  localparam logic [15:0] CAS_BIT      = 16'h0020;
  localparam logic [7:0]  VEC_PLAIN    = 8'h30;
  localparam logic [7:0]  VEC_ALT      = 8'hBC;
  localparam logic [15:0] SCROLL_RESET = 16'o1330;
  localparam logic [7:0]  SHIFT_DOWN   = 8'd16;
  localparam logic [7:0]  SHIFT_UP     = 8'd32;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } scan_result_t;

endpackage

FILE: hw/rtl/ksrp_in_if.sv
interface ksrp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  reg_select;
  logic [15:0] write_data;
  logic [63:0] rows_low;
  logic [23:0] rows_high;
  logic [7:0]  modifiers;
  logic        cassette_high;

  modport source (
    output valid, command, reg_select, write_data, rows_low, rows_high, modifiers,
           cassette_high,
    input  ready
  );
  modport sink (
    input  valid, command, reg_select, write_data, rows_low, rows_high, modifiers,
           cassette_high,
    output ready
  );
endinterface

FILE: hw/rtl/ksrp_out_if.sv
interface ksrp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_line;
  logic [7:0]  vector;

  modport source (output valid, read_data, irq_line, vector, input ready);
  modport sink (input valid, read_data, irq_line, vector, output ready);
endinterface

FILE: hw/rtl/ksrp_scan.sv
module ksrp_scan (
  input  logic [63:0]               rows_low,
  input  logic [23:0]               rows_high,
  input  logic [7:0]                modifiers,
  input  logic [7:0]                key_code,
  output ksrp_pkg::scan_result_t    result
);

  logic [ksrp_pkg::NUM_ROWS*8-1:0] rows;
  logic [7:0] row_byte;
  logic [3:0] row;
  logic [2:0] col;
  logic [7:0] base_code;

  assign rows = {rows_high, rows_low};

  // first nonzero row wins: walk from the top so the lowest row is written last
  always_comb begin
    row_byte = '0;
    row      = '0;
    for (int i = ksrp_pkg::NUM_ROWS - 1; i >= 0; i--) begin
      if (rows[i*8 +: 8] != 8'd0) begin
        row_byte = rows[i*8 +: 8];
        row      = 4'(i + 1);
      end
    end
  end

  always_comb begin
    col = '0;
    for (int c = 0; c < 8; c++) begin
      if (row_byte[c]) col = 3'(c);
    end
  end

  always_comb begin
    base_code = $onehot(row_byte) ? {1'b0, row[3:0], col} : key_code;
    result.hit  = row_byte != 8'd0;
    result.code = base_code;
    if (modifiers[ksrp_pkg::SHIFT_BIT]) begin
      if (row == 4'd6 || row == 4'd7) result.code = base_code - ksrp_pkg::SHIFT_DOWN;
      else if (row >= 4'd8)          result.code = base_code + ksrp_pkg::SHIFT_UP;
    end
  end

endmodule

FILE: hw/rtl/keyboard_scan_register_port.sv
// Keyboard and scroll register port. Every transaction (scan tick, bus read,
// bus write or interrupt acknowledge) gives exactly one result. The block
// takes one transaction per clock while the output side is not stalled. An
// accepted transaction is held in the input register, then the register
// update and row priority encode land in the result register. Input
// ready follows the output side; a stalled result holds both stages. irq_line
// is the request level after the transaction, and scroll resets to octal 1330.
module keyboard_scan_register_port (
  input logic         clk,
  input logic         rst,
  ksrp_in_if.sink     in_ch,
  ksrp_out_if.source  out_ch
);

  // input register
  logic        s1_valid;
  logic [1:0]  s1_command;
  logic [2:0]  s1_reg_select;
  logic [15:0] s1_write_data;
  logic [63:0] s1_rows_low;
  logic [23:0] s1_rows_high;
  logic [7:0]  s1_modifiers;
  logic        s1_cassette_high;

  // block state
  logic [7:0]  key_code;
  logic        key_pressed;
  logic        mask_bit;
  logic [7:0]  irq_vector;
  logic        irq_pending;
  logic [15:0] scroll_offset;

  logic [7:0]  key_code_next;
  logic        key_pressed_next;
  logic        mask_bit_next;
  logic [7:0]  irq_vector_next;
  logic        irq_pending_next;
  logic [15:0] scroll_offset_next;
  logic [15:0] read_data_next;
  logic [7:0]  vector_next;

  logic advance;
  logic fire;
  ksrp_pkg::scan_result_t scan;

  assign advance      = !out_ch.valid || out_ch.ready;
  assign fire         = s1_valid && advance;
  assign in_ch.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_command       <= in_ch.command;
      s1_reg_select    <= in_ch.reg_select;
      s1_write_data    <= in_ch.write_data;
      s1_rows_low      <= in_ch.rows_low;
      s1_rows_high     <= in_ch.rows_high;
      s1_modifiers     <= in_ch.modifiers;
      s1_cassette_high <= in_ch.cassette_high;
    end
  end

  ksrp_scan u_scan (
    .rows_low  (s1_rows_low),
    .rows_high (s1_rows_high),
    .modifiers (s1_modifiers),
    .key_code  (key_code),
    .result    (scan)
  );

  always_comb begin
    key_code_next      = key_code;
    key_pressed_next   = key_pressed;
    mask_bit_next      = mask_bit;
    irq_vector_next    = irq_vector;
    irq_pending_next   = irq_pending;
    scroll_offset_next = scroll_offset;
    read_data_next     = '0;
    vector_next        = '0;
    case (s1_command)
      ksrp_pkg::CMD_SCAN: begin
        if (scan.hit) begin
          key_code_next    = scan.code;
          key_pressed_next = 1'b1;
          irq_vector_next  = s1_modifiers[ksrp_pkg::VEC_SEL_BIT] ? ksrp_pkg::VEC_ALT
                                                                 : ksrp_pkg::VEC_PLAIN;
          irq_pending_next = 1'b1;
        end
      end
      ksrp_pkg::CMD_READ: begin
        case (s1_reg_select)
          ksrp_pkg::REG_STATE: begin
            read_data_next = 16'(mask_bit) << ksrp_pkg::MASK_BIT_POS;
          end
          ksrp_pkg::REG_CODE: begin
            read_data_next   = {8'd0, key_code};
            key_pressed_next = 1'b0;
          end
          ksrp_pkg::REG_STATUS: begin
            read_data_next = ksrp_pkg::STATUS_BASE
                           | (16'(key_pressed) << ksrp_pkg::MASK_BIT_POS)
                           | (s1_cassette_high ? ksrp_pkg::CAS_BIT : 16'd0);
          end
          ksrp_pkg::REG_SCROLL: begin
            read_data_next = scroll_offset;
          end
          default: begin
            read_data_next = '0;
          end
        endcase
      end
      ksrp_pkg::CMD_WRITE: begin
        if (s1_reg_select == ksrp_pkg::REG_STATE) begin
          mask_bit_next = s1_write_data[ksrp_pkg::MASK_BIT_POS];
        end else if (s1_reg_select == ksrp_pkg::REG_SCROLL) begin
          scroll_offset_next = s1_write_data;
        end
      end
      default: begin
        irq_pending_next = 1'b0;
        vector_next      = irq_vector;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_code      <= '0;
      key_pressed   <= 1'b0;
      mask_bit      <= 1'b0;
      irq_vector    <= '0;
      irq_pending   <= 1'b0;
      scroll_offset <= ksrp_pkg::SCROLL_RESET;
      out_ch.valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_ch.valid <= s1_valid;
      end
      if (fire) begin
        key_code      <= key_code_next;
        key_pressed   <= key_pressed_next;
        mask_bit      <= mask_bit_next;
        irq_vector    <= irq_vector_next;
        irq_pending   <= irq_pending_next;
        scroll_offset <= scroll_offset_next;
      end
    end
    if (fire) begin
      out_ch.read_data <= read_data_next;
      out_ch.irq_line  <= irq_pending_next;
      out_ch.vector    <= vector_next;
    end
  end

  // acknowledge always drops the request
  ack_drops_irq: assert property (@(posedge clk) disable iff (rst)
    fire && s1_command == ksrp_pkg::CMD_ACK |=> !irq_pending)
    else $error("interrupt request still pending after acknowledge");

  // a new key press always comes with a request
  press_raises_irq: assert property (@(posedge clk) disable iff (rst)
    $rose(key_pressed) |-> irq_pending)
    else $error("key pressed without interrupt request");

  // read data and vector never both carry a value
  read_or_vector: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.read_data == 16'd0 || out_ch.vector == 8'd0))
    else $error("result carries both read data and vector");

  // a result with a vector is an acknowledge, so the request is low
  vector_irq_low: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.vector != 8'd0 |-> !out_ch.irq_line)
    else $error("vector returned while request still high");

endmodule
